[src/assert_macros.svh]
// Assertion macros shared by the transmit queue RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/tpfq_pkg.sv]
// Shared types, codes and frame classification for the transmit queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpfq_pkg;
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int BATCH_MAX_DEF = 3;
	localparam int HDR_W = 34;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAP = 2'd2;

	localparam logic [2:0] ST_PUSHED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_BAD_CH = 3'd2;
	localparam logic [2:0] ST_POPPED = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_PUSH, S_P0, S_P1, S_P2, S_EMPTY, S_P3, S_FCHK, S_FWAIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic push_do;
		logic sel1;
		logic cap0;
		logic pick;
		logic empty_do;
		logic take;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic in_pop;
		logic out_ok;
		logic found;
		logic qual;
		logic pend;
	} sts_t;

	function automatic logic is_control(input logic [28:0] id, input logic [3:0] dlc,
			input logic [63:0] pl);
		logic [7:0] top;
		top = pl[63:56];
		is_control = (id == 29'h7FF) || ((dlc == 4'd8) && (pl[55:0] == {56{1'b1}}) &&
			(top == 8'hFC || top == 8'hFD || top == 8'hFE));
	endfunction
endpackage
`default_nettype wire

[src/tpfq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tpfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[src/tpfq_ctrl.sv]
// Sequencer for push, pick and batch pop of the transmit queue.
// Depends on tpfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpfq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire tpfq_pkg::sts_t sts,
	output tpfq_pkg::cmd_t cmd
);
	tpfq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tpfq_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tpfq_pkg::S_IDLE: if (in_valid) state_d = sts.in_pop ? tpfq_pkg::S_P0
					: tpfq_pkg::S_PUSH;
			tpfq_pkg::S_PUSH: if (sts.out_ok) state_d = tpfq_pkg::S_IDLE;
			tpfq_pkg::S_P0: state_d = tpfq_pkg::S_P1;
			tpfq_pkg::S_P1: state_d = tpfq_pkg::S_P2;
			tpfq_pkg::S_P2: state_d = sts.found ? tpfq_pkg::S_P3 : tpfq_pkg::S_EMPTY;
			tpfq_pkg::S_EMPTY: if (sts.out_ok) state_d = tpfq_pkg::S_IDLE;
			tpfq_pkg::S_P3: state_d = tpfq_pkg::S_FCHK;
			tpfq_pkg::S_FCHK: begin
				if (!sts.pend || sts.out_ok)
					state_d = sts.qual ? tpfq_pkg::S_FWAIT : tpfq_pkg::S_IDLE;
			end
			tpfq_pkg::S_FWAIT: state_d = tpfq_pkg::S_FCHK;
			default: state_d = tpfq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			tpfq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			tpfq_pkg::S_PUSH: cmd.push_do = sts.out_ok;
			tpfq_pkg::S_P0: cmd.sel1 = 1'b1;
			tpfq_pkg::S_P1: cmd.cap0 = 1'b1;
			tpfq_pkg::S_P2: cmd.pick = 1'b1;
			tpfq_pkg::S_EMPTY: cmd.empty_do = sts.out_ok;
			tpfq_pkg::S_FCHK: begin
				if (!sts.pend || sts.out_ok) begin
					cmd.emit = sts.pend;
					cmd.take = sts.qual;
				end
			end
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

[src/tpfq_dp.sv]
// Datapath: config registers, FIFO pointers, frame memories, pick logic, output register.
// Depends on tpfq_pkg, tpfq_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tpfq_dp #(
	parameter int QUEUE_DEPTH = tpfq_pkg::QUEUE_DEPTH_DEF,
	parameter int BATCH_MAX = tpfq_pkg::BATCH_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [tpfq_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tpfq_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic action,
	input wire logic channel,
	input wire logic [28:0] frame_id,
	input wire logic [3:0] frame_dlc,
	input wire logic [63:0] frame_payload,
	input wire tpfq_pkg::cmd_t cmd,
	output tpfq_pkg::sts_t sts,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic out_channel,
	output logic [28:0] out_id,
	output logic [3:0] out_dlc,
	output logic [63:0] out_payload,
	output logic last
);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(2 * QUEUE_DEPTH);
	localparam int KW = $clog2(BATCH_MAX + 1);
	localparam int SW = (CW + 1 > 7) ? CW + 1 : 7;

	logic [1:0] mask_q;
	logic order_q;
	logic [6:0] cap_q;
	logic [IW-1:0] heads_q [2];
	logic [CW-1:0] counts_q [2];
	logic [6:0] held_q;
	logic next_slot_q;
	logic ch_in_q;
	logic [28:0] id_in_q;
	logic [3:0] dlc_in_q;
	logic [63:0] pl_in_q;
	logic rd_ch_q, ctrl0_q, cls_q, pend_q;
	logic [KW-1:0] k_q;
	logic [tpfq_pkg::HDR_W-1:0] pend_hdr_q, hdr_rd;
	logic [63:0] pend_pl_q, pl_rd;

	// push decision
	logic [CW:0] tail_sum, tail_w;
	logic [AW-1:0] waddr, raddr;
	logic push_en, push_full, push_wr;
	logic [2:0] push_status;

	always_comb begin
		tail_sum = (CW+1)'(heads_q[ch_in_q]) + (CW+1)'(counts_q[ch_in_q]);
		tail_w = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ? tail_sum - (CW+1)'(QUEUE_DEPTH)
			: tail_sum;
		waddr = ch_in_q ? AW'(QUEUE_DEPTH) + AW'(tail_w[IW-1:0]) : AW'(tail_w[IW-1:0]);
		raddr = rd_ch_q ? AW'(QUEUE_DEPTH) + AW'(heads_q[rd_ch_q])
			: AW'(heads_q[rd_ch_q]);
		push_en = mask_q[ch_in_q];
		push_full = (held_q >= cap_q) || (counts_q[ch_in_q] >= CW'(QUEUE_DEPTH));
		push_status = !push_en ? tpfq_pkg::ST_BAD_CH
			: (push_full ? tpfq_pkg::ST_FULL : tpfq_pkg::ST_PUSHED);
		push_wr = cmd.push_do && push_en && !push_full;
	end

	tpfq_ram #(.WIDTH(tpfq_pkg::HDR_W), .DEPTH(2 * QUEUE_DEPTH)) u_hdr_ram (
		.clk(clk), .we(push_wr), .waddr(waddr),
		.wdata({tpfq_pkg::is_control(id_in_q, dlc_in_q, pl_in_q), dlc_in_q, id_in_q}),
		.raddr(raddr), .rdata(hdr_rd)
	);

	tpfq_ram #(.WIDTH(64), .DEPTH(2 * QUEUE_DEPTH)) u_pl_ram (
		.clk(clk), .we(push_wr), .waddr(waddr), .wdata(pl_in_q),
		.raddr(raddr), .rdata(pl_rd)
	);

	// channel pick: control heads first, then any non-empty, round robin
	logic c_first, c_second, av_f, av_s, ct_f, ct_s, sel_ch, sel_ctl, found;
	always_comb begin
		c_first = (mask_q == 2'b11) ? (order_q ^ next_slot_q) : !mask_q[0];
		c_second = !c_first;
		av_f = mask_q[c_first] && (counts_q[c_first] != '0);
		av_s = mask_q[c_second] && (counts_q[c_second] != '0);
		ct_f = c_first ? hdr_rd[tpfq_pkg::HDR_W-1] : ctrl0_q;
		ct_s = c_second ? hdr_rd[tpfq_pkg::HDR_W-1] : ctrl0_q;
		found = av_f || av_s;
		if (av_f && ct_f) sel_ch = c_first;
		else if (av_s && ct_s) sel_ch = c_second;
		else if (av_f) sel_ch = c_first;
		else sel_ch = c_second;
		sel_ctl = (sel_ch == c_first) ? ct_f : ct_s;
	end

	logic qual, out_ok;
	assign qual = (k_q < KW'(BATCH_MAX)) && (counts_q[rd_ch_q] != '0) &&
		(hdr_rd[tpfq_pkg::HDR_W-1] == cls_q);
	assign out_ok = !out_valid || !out_stall;

	always_comb begin
		sts.in_pop = action;
		sts.out_ok = out_ok;
		sts.found = found;
		sts.qual = qual;
		sts.pend = pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 2'b11;
			order_q <= 1'b0;
			cap_q <= 7'd64;
			heads_q[0] <= '0;
			heads_q[1] <= '0;
			counts_q[0] <= '0;
			counts_q[1] <= '0;
			held_q <= '0;
			next_slot_q <= 1'b0;
			rd_ch_q <= 1'b0;
			pend_q <= 1'b0;
			k_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tpfq_pkg::REG_MASK: mask_q <= cfg_data[1:0];
					tpfq_pkg::REG_ORDER: order_q <= cfg_data[0];
					tpfq_pkg::REG_CAP: cap_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.push_do || cmd.empty_do || cmd.emit)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (cmd.accept)
				rd_ch_q <= 1'b0;
			if (cmd.sel1)
				rd_ch_q <= 1'b1;
			if (push_wr) begin
				counts_q[ch_in_q] <= counts_q[ch_in_q] + 1'b1;
				held_q <= held_q + 1'b1;
			end
			if (cmd.pick && found) begin
				rd_ch_q <= sel_ch;
				next_slot_q <= (mask_q == 2'b11) ? !(sel_ch ^ order_q) : 1'b0;
				k_q <= '0;
			end
			if (cmd.take)
				pend_q <= 1'b1;
			else if (cmd.emit || (cmd.pick && found))
				pend_q <= 1'b0;
			if (cmd.take) begin
				k_q <= k_q + 1'b1;
				heads_q[rd_ch_q] <= (heads_q[rd_ch_q] == IW'(QUEUE_DEPTH - 1)) ? '0
					: heads_q[rd_ch_q] + 1'b1;
				counts_q[rd_ch_q] <= counts_q[rd_ch_q] - 1'b1;
				held_q <= held_q - 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_in_q <= channel;
			id_in_q <= frame_id;
			dlc_in_q <= frame_dlc;
			pl_in_q <= frame_payload;
		end
		if (cmd.cap0)
			ctrl0_q <= hdr_rd[tpfq_pkg::HDR_W-1];
		if (cmd.pick)
			cls_q <= sel_ctl;
		if (cmd.take) begin
			pend_hdr_q <= hdr_rd;
			pend_pl_q <= pl_rd;
		end
		if (cmd.push_do || cmd.empty_do) begin
			status <= cmd.push_do ? push_status : tpfq_pkg::ST_EMPTY;
			out_channel <= 1'b0;
			out_id <= '0;
			out_dlc <= '0;
			out_payload <= '0;
			last <= 1'b1;
		end
		if (cmd.emit) begin
			status <= tpfq_pkg::ST_POPPED;
			out_channel <= rd_ch_q;
			out_id <= pend_hdr_q[28:0];
			out_dlc <= pend_hdr_q[32:29];
			out_payload <= pend_pl_q;
			last <= !qual;
		end
	end

	`ASSERT_ALWAYS(a_held_sum, (SW'(held_q) == SW'(counts_q[0]) + SW'(counts_q[1])),
		"frame total out of step with channel fills")
	`ASSERT_ALWAYS(a_batch_bound, (k_q <= KW'(BATCH_MAX)), "batch ran past its limit")
	`ASSERT_NEXT(a_take_nonempty, cmd.take, (pend_q && out_valid == $past(out_valid ||
		cmd.emit) || pend_q), "taken frame not held for output")
	`ASSERT_ALWAYS(a_fill_bound, (counts_q[0] <= CW'(QUEUE_DEPTH) &&
		counts_q[1] <= CW'(QUEUE_DEPTH)), "channel fill above queue depth")
endmodule
`default_nettype wire

[src/two_channel_priority_fair_tx_queue.sv]
// Two-channel CAN transmit queue sharing one capacity. One item is taken at a time, only
// while the block is idle. A push gives its result from state PUSH once the output register
// is free. A pop reads both channel heads through the single read port of the frame memory
// in P0 and P1 and picks a channel in P2; an empty pop reports from EMPTY, otherwise the
// chosen head is read in P3 and each frame is taken in FCHK, with a wait in FWAIT between
// frames, since each new head is read from that memory after the pointer advances. The
// result is held in an output register until taken; output stalls hold the sequence back.
// Frame memory holds 2*QUEUE_DEPTH entries.
// Depends on tpfq_pkg, tpfq_ctrl and tpfq_dp.
`timescale 1ns / 1ps
`default_nettype none
module two_channel_priority_fair_tx_queue #(
	parameter int QUEUE_DEPTH = tpfq_pkg::QUEUE_DEPTH_DEF,
	parameter int BATCH_MAX = tpfq_pkg::BATCH_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [tpfq_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tpfq_pkg::CFG_DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic action,
	input wire logic channel,
	input wire logic [28:0] frame_id,
	input wire logic [3:0] frame_dlc,
	input wire logic [63:0] frame_payload,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic out_channel,
	output logic [28:0] out_id,
	output logic [3:0] out_dlc,
	output logic [63:0] out_payload,
	output logic last
);
	tpfq_pkg::cmd_t cmd;
	tpfq_pkg::sts_t sts;

	tpfq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	tpfq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .BATCH_MAX(BATCH_MAX)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.action(action), .channel(channel), .frame_id(frame_id),
		.frame_dlc(frame_dlc), .frame_payload(frame_payload),
		.cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.out_channel(out_channel), .out_id(out_id), .out_dlc(out_dlc),
		.out_payload(out_payload), .last(last)
	);
endmodule
`default_nettype wire

[dv/two_channel_priority_fair_tx_queue_tb.sv]
// Testbench for the two-channel transmit queue: directed frames, then random push/pop traffic
// over several register settings, checked against a built-in queue predictor.
// Depends on tpfq_pkg and two_channel_priority_fair_tx_queue.
`timescale 1ns / 1ps
module two_channel_priority_fair_tx_queue_tb;
	localparam int DEPTH = tpfq_pkg::QUEUE_DEPTH_DEF;
	localparam int BATCH = tpfq_pkg::BATCH_MAX_DEF;
	localparam int LIMIT = 400000;

	typedef struct {
		logic action;
		logic ch;
		logic [28:0] id;
		logic [3:0] dlc;
		logic [63:0] pl;
		bit typed;
		logic [2:0] st;
	} item_t;

	typedef struct {
		logic [2:0] st;
		logic ch;
		logic [28:0] id;
		logic [3:0] dlc;
		logic [63:0] pl;
		logic last;
	} txres_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [tpfq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tpfq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic action = 0, channel = 0;
	logic [28:0] frame_id = '0;
	logic [3:0] frame_dlc = '0;
	logic [63:0] frame_payload = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic out_channel;
	logic [28:0] out_id;
	logic [3:0] out_dlc;
	logic [63:0] out_payload;
	logic last;

	two_channel_priority_fair_tx_queue uut (.*);

	always #4 clk = ~clk;

	// predictor state
	logic [63:0] pl_mem [2*DEPTH];
	logic [33:0] hdr_mem [2*DEPTH];
	int q_head [2];
	int q_cnt [2];
	int held, rr_slot;
	logic [1:0] m_mask;
	logic m_order;
	logic [6:0] m_cap;

	txres_t txq [$];
	int errors = 0;
	int cyc = 0;
	bit idle_on = 1;
	logic hold_start = 0;
	int hold_cnt = 0;

	function automatic bit ctl_frame(logic [28:0] id, logic [3:0] dlc, logic [63:0] pl);
		logic [7:0] top = pl[63:56];
		return id == 29'h7FF || (dlc == 4'd8 && pl[55:0] == {56{1'b1}} &&
			(top == 8'hFC || top == 8'hFD || top == 8'hFE));
	endfunction

	function automatic txres_t status_only(logic [2:0] st);
		txres_t r;
		r.st = st; r.ch = 0; r.id = 0; r.dlc = 0; r.pl = 0; r.last = 1;
		return r;
	endfunction

	function automatic void exp_add(txres_t r);
		txq = {txq, r};
	endfunction

	function automatic bit head_ctl(int c);
		return hdr_mem[c*DEPTH + q_head[c]][33];
	endfunction

	function automatic void predict_queue(item_t it);
		int lst [2];
		int n = 0, sel = -1, c, k, s;
		bit cls;
		txres_t r;
		if (it.action == 1'b0) begin
			c = it.ch;
			if (!m_mask[c]) exp_add(status_only(tpfq_pkg::ST_BAD_CH));
			else if (held >= m_cap || q_cnt[c] >= DEPTH)
				exp_add(status_only(tpfq_pkg::ST_FULL));
			else begin
				s = c*DEPTH + (q_head[c] + q_cnt[c]) % DEPTH;
				pl_mem[s] = it.pl;
				hdr_mem[s] = {ctl_frame(it.id, it.dlc, it.pl), it.dlc, it.id};
				q_cnt[c]++;
				held++;
				exp_add(status_only(tpfq_pkg::ST_PUSHED));
			end
			return;
		end
		if (m_mask[m_order]) lst[n++] = m_order;
		if (m_mask[!m_order]) lst[n++] = !m_order;
		for (int pass = 0; pass < 2 && sel < 0; pass++)
			for (int o = 0; o < n && sel < 0; o++) begin
				int i = (rr_slot + o) % n;
				if (q_cnt[lst[i]] != 0 && (pass == 1 || head_ctl(lst[i]))) sel = i;
			end
		if (sel < 0) begin
			exp_add(status_only(tpfq_pkg::ST_EMPTY));
			return;
		end
		c = lst[sel];
		cls = head_ctl(c);
		k = 0;
		while (k < BATCH && q_cnt[c] != 0 && head_ctl(c) == cls) begin
			s = c*DEPTH + q_head[c];
			r.st = tpfq_pkg::ST_POPPED; r.ch = c; r.id = hdr_mem[s][28:0];
			r.dlc = hdr_mem[s][32:29]; r.pl = pl_mem[s]; r.last = 0;
			exp_add(r);
			q_head[c] = (q_head[c] + 1) % DEPTH;
			q_cnt[c]--;
			held--;
			k++;
		end
		txq[txq.size()-1].last = 1;
		rr_slot = (sel + 1) % n;
	endfunction

	function automatic item_t mk(logic a, logic c, logic [28:0] id, logic [3:0] dlc,
			logic [63:0] pl, bit typed = 0, logic [2:0] st = tpfq_pkg::ST_PUSHED);
		item_t it;
		it.action = a; it.ch = c; it.id = id; it.dlc = dlc; it.pl = pl;
		it.typed = typed; it.st = st;
		return it;
	endfunction

	function automatic item_t rand_item(int pop_pct);
		logic [28:0] id;
		logic [3:0] dlc;
		logic [63:0] pl;
		case ($urandom_range(0, 5))
			0: id = 29'h7FF;
			1: id = 29'h1FFFFFFF;
			2: id = 29'h7FE;
			default: id = 29'($urandom());
		endcase
		dlc = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
		pl = {$urandom(), $urandom()};
		if ($urandom_range(0, 2) == 0)
			pl = {8'hFB + 8'($urandom_range(0, 4)), 56'hFFFFFFFFFFFFFF};
		if ($urandom_range(0, 9) == 0) pl[8*$urandom_range(0, 6) +: 8] = 8'($urandom());
		return mk($urandom_range(0, 99) < pop_pct, 1'($urandom_range(0, 1)), id, dlc, pl);
	endfunction

	// offer one item, hold it until taken, then drop valid
	task automatic send(item_t it);
		int n_before;
		if (idle_on && $urandom_range(0, 99) < 16)
			repeat ($urandom_range(1, 4)) @(posedge clk);
		in_valid <= 1;
		action <= it.action; channel <= it.ch; frame_id <= it.id;
		frame_dlc <= it.dlc; frame_payload <= it.pl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (it.typed) begin
			n_before = txq.size();
			predict_queue(it);
			while (txq.size() > n_before) void'(txq.pop_back());
			exp_add(status_only(it.st));
		end else predict_queue(it);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (txq.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg(logic [tpfq_pkg::CFG_IDX_W-1:0] idx,
			logic [tpfq_pkg::CFG_DATA_W-1:0] val);
		cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
		case (idx)
			tpfq_pkg::REG_MASK: m_mask = val[1:0];
			tpfq_pkg::REG_ORDER: m_order = val[0];
			default: m_cap = val;
		endcase
	endtask

	// receiver: check each taken result, then decide next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (txq.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result status %0d", status);
			end else begin
				txres_t e;
				e = txq[0];
				txq.delete(0);
				if ({status, out_channel, out_id, out_dlc, out_payload, last} !==
						{e.st, e.ch, e.id, e.dlc, e.pl, e.last}) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st=%0d ch=%0d id=%h dlc=%0d pl=%h last=%0d, got st=%0d ch=%0d id=%h dlc=%0d pl=%h last=%0d",
							e.st, e.ch, e.id, e.dlc, e.pl, e.last,
							status, out_channel, out_id, out_dlc, out_payload, last);
				end
			end
		end
		out_stall <= (hold_cnt > 1) || (idle_on && $urandom_range(0, 99) < 16);
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_start) hold_cnt <= 300;
		else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("two_channel_priority_fair_tx_queue verification failed");
			$finish;
		end
	end

	initial begin
		item_t dir [$];
		logic [63:0] ctl_pl = {8'hFC, 56'hFFFFFFFFFFFFFF};
		logic [6:0] set_mask [7] = '{3, 1, 2, 0, 3, 3, 3};
		logic [6:0] set_order [7] = '{0, 1, 0, 1, 1, 0, 1};
		logic [6:0] set_cap [7] = '{64, 5, 1, 64, 0, 127, 64};

		for (int i = 0; i < 2*DEPTH; i++) begin
			pl_mem[i] = 0; hdr_mem[i] = 0;
		end
		q_head = '{0, 0}; q_cnt = '{0, 0}; held = 0; rr_slot = 0;
		m_mask = 2'd3; m_order = 0; m_cap = 7'd64;

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir = {dir, mk(1, 0, 0, 0, 0, 1, tpfq_pkg::ST_EMPTY)};
		dir = {dir, mk(0, 0, 0, 0, 0, 1, tpfq_pkg::ST_PUSHED)};
		dir = {dir, mk(0, 0, 29'h1FFFFFFF, 4'd15, '1, 1, tpfq_pkg::ST_PUSHED)};
		dir = {dir, mk(0, 1, 29'h7FF, 4'd3, 64'h0123456789ABCDEF, 1, tpfq_pkg::ST_PUSHED)};
		dir = {dir, mk(0, 1, 29'h12, 4'd8, ctl_pl)};
		dir = {dir, mk(0, 0, 29'h13, 4'd8, {8'hFD, 56'hFFFFFFFFFFFFFF})};
		dir = {dir, mk(0, 0, 29'h14, 4'd8, {8'hFE, 56'hFFFFFFFFFFFFFF})};
		dir = {dir, mk(0, 0, 29'h15, 4'd8, {8'hFF, 56'hFFFFFFFFFFFFFF})};
		dir = {dir, mk(0, 1, 29'h16, 4'd9, ctl_pl)};
		dir = {dir, mk(0, 1, 29'h17, 4'd8, {8'hFC, 56'hFFFFFFFFFFFF7F})};
		dir = {dir, mk(0, 0, 29'h7FE, 4'd2, 64'h5555AAAA5555AAAA)};
		dir = {dir, mk(0, 0, 29'h7FF, 4'd8, ctl_pl)};
		for (int i = 0; i < 7; i++) dir = {dir, mk(1, 0, 0, 0, 0)};
		dir = {dir, mk(1, 1, 0, 0, 0, 1, tpfq_pkg::ST_EMPTY)};

		foreach (dir[i]) send(dir[i]);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			cfg(tpfq_pkg::REG_MASK, set_mask[ph]);
			cfg(tpfq_pkg::REG_ORDER, set_order[ph]);
			cfg(tpfq_pkg::REG_CAP, set_cap[ph]);
			idle_on = (ph != 2);
			if (ph == 5) begin
				// fill channel 0 past its own FIFO depth, then drain
				for (int i = 0; i < 70; i++) begin
					item_t it = rand_item(0);
					it.ch = 0;
					send(it);
				end
				for (int i = 0; i < 20; i++) send(rand_item(85));
			end else begin
				for (int i = 0; i < 16; i++) begin
					if (ph == 1 && i == 4) begin
						hold_start <= 1;
						@(posedge clk);
						hold_start <= 0;
					end
					if (ph == 3 && i == 8) drain();
					send(rand_item(ph == 6 ? 70 : 40));
				end
			end
			drain();
		end

		cfg(tpfq_pkg::REG_MASK, 3);
		for (int i = 0; i < 20; i++) send(mk(1, 0, 0, 0, 0));
		drain();

		if (errors == 0)
			$display("two_channel_priority_fair_tx_queue verification clean");
		else
			$display("two_channel_priority_fair_tx_queue verification failed");
		$finish;
	end
endmodule

[filelist.f]
+incdir+src
src/tpfq_pkg.sv
src/tpfq_ram.sv
src/tpfq_ctrl.sv
src/tpfq_dp.sv
src/two_channel_priority_fair_tx_queue.sv
dv/two_channel_priority_fair_tx_queue_tb.sv
